### rtl/core/bgi_pkg.sv
// Shared constants, codes and types for the bilinear grid interpolator.
// No dependencies; imported by bgi_axis and the core top level (bgi_ram does not use it).
package bgi_pkg;

    localparam int DATA_W       = 32;
    localparam int IDX_W        = 12;
    localparam int NPTS_W       = 7;
    localparam int AXIS_DEPTH   = 64;
    localparam int AXIS_AW      = $clog2(AXIS_DEPTH);
    localparam int SAMPLE_DEPTH = 4096;
    localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);
    localparam int CFG_IDX_W    = 1;
    localparam int S_TDATA_W    = 112;
    localparam int M_TDATA_W    = 32;
    localparam int DIV_STEPS    = DATA_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    // request kinds (s_tuser)
    localparam logic [1:0] FUNC_WR_X   = 2'd0;
    localparam logic [1:0] FUNC_WR_Y   = 2'd1;
    localparam logic [1:0] FUNC_WR_S   = 2'd2;
    localparam logic [1:0] FUNC_QUERY  = 2'd3;

    // result status (m_tuser)
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_SAT    = 2'd1;
    localparam logic [1:0] STAT_ZERO_W = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REG_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_Y = 1'd1;

    localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic                      en;
        logic [AXIS_AW-1:0]        addr;
        logic [DATA_W-1:0]         data;
    } axis_wr_t;

    typedef struct packed {
        logic                      busy;
        logic [AXIS_AW-1:0]        j;
        logic [DATA_W-1:0]         g_lo;
        logic [DATA_W-1:0]         g_hi;
    } axis_res_t;

endpackage

### rtl/core/bgi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/bgi_axis.sv
// One grid axis: point store plus clamped halving search for the interval.
// Depends on bgi_pkg and bgi_ram.
module bgi_axis (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bgi_pkg::axis_wr_t               wr,
    input  logic                            start,
    input  logic signed [bgi_pkg::DATA_W-1:0] coord,
    input  logic [bgi_pkg::NPTS_W-1:0]      npts,
    output bgi_pkg::axis_res_t              res
);
    import bgi_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHK0   = 3'd1;
    localparam logic [2:0] S_CHKN   = 3'd2;
    localparam logic [2:0] S_MIDRD  = 3'd3;
    localparam logic [2:0] S_MIDCHK = 3'd4;
    localparam logic [2:0] S_FLO    = 3'd5;
    localparam logic [2:0] S_FHI    = 3'd6;
    localparam logic [2:0] S_FDONE  = 3'd7;

    logic [2:0]               state_reg, state_next;
    logic signed [DATA_W-1:0] x_reg;
    logic [NPTS_W-1:0]        n_reg, len_reg, len_next, half, half_next;
    logic [AXIS_AW-1:0]       lo_reg, lo_next, mid, nm2, jc, j_reg;
    logic                     early_reg;
    logic [DATA_W-1:0]        g_lo_reg, g_hi_reg;
    logic [AXIS_AW-1:0]       rd_addr;
    logic [DATA_W-1:0]        rdata;
    logic signed [DATA_W-1:0] g;

    assign g         = $signed(rdata);
    assign nm2       = AXIS_AW'(n_reg - NPTS_W'(2));
    assign half      = len_reg >> 1;
    assign mid       = AXIS_AW'(NPTS_W'(lo_reg) + half);
    assign len_next  = len_reg - half;
    assign half_next = len_next >> 1;
    assign lo_next   = (x_reg > g) ? mid : lo_reg;
    assign jc        = (lo_reg > nm2) ? nm2 : lo_reg;

    bgi_ram #(.WIDTH(DATA_W), .DEPTH(AXIS_DEPTH)) u_pts (
        .clk   (aclk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_comb begin
        rd_addr    = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (start) state_next = S_CHK0;
            S_CHK0: begin
                rd_addr    = nm2;
                state_next = S_CHKN;
            end
            S_CHKN: begin
                if (early_reg || x_reg >= g) state_next = S_FLO;
                else                         state_next = S_MIDRD;
            end
            S_MIDRD: begin
                rd_addr    = mid;
                state_next = S_MIDCHK;
            end
            S_MIDCHK: state_next = (half_next == '0) ? S_FLO : S_MIDRD;
            S_FLO: begin
                rd_addr    = jc;
                state_next = S_FHI;
            end
            S_FHI: begin
                rd_addr    = j_reg + AXIS_AW'(1);
                state_next = S_FDONE;
            end
            S_FDONE:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    x_reg <= coord;
                    n_reg <= npts;
                end
            end
            S_CHK0: early_reg <= (x_reg <= g);
            S_CHKN: begin
                len_reg <= n_reg;
                if (early_reg)       lo_reg <= '0;
                else if (x_reg >= g) lo_reg <= nm2;
                else                 lo_reg <= '0;
            end
            S_MIDRD: ;
            S_MIDCHK: begin
                lo_reg  <= lo_next;
                len_reg <= len_next;
            end
            S_FLO:   j_reg    <= jc;
            S_FHI:   g_lo_reg <= rdata;
            S_FDONE: g_hi_reg <= rdata;
            default: ;
        endcase
    end

    assign res.busy = (state_reg != S_IDLE);
    assign res.j    = j_reg;
    assign res.g_lo = g_lo_reg;
    assign res.g_hi = g_hi_reg;

endmodule

### rtl/core/bilinear_grid_interpolator_core.sv
// Top level of the bilinear grid interpolator: request decode, corner
// accumulation, restoring divide and result register.
// Depends on bgi_pkg, bgi_ram and bgi_axis.
//
//  port group      | dir | contents
//  ----------------+-----+-------------------------------------------------
//  s_t*            | in  | write-point / write-sample / query requests
//  m_t*            | out | one interpolated result per query
//  cfg_*           | in  | point counts per axis (no read-back)
//
// Query flow: a write request is taken while the core is idle. A query runs
//   the two axis searches side by side (a halving step on each point RAM),
//   then per corner sample a RAM read, two 32x32 partial products and an
//   accumulate, then a 32-step restoring divide (skipped on zero width or overflow).
// Reset: aresetn is synchronous, active low; stores are not cleared.
// Stalls: a finished result waits in the output register; new requests are
//   taken meanwhile, but a query holds before its result until it drains.
module bilinear_grid_interpolator_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_we,
    input  logic [bgi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bgi_pkg::NPTS_W-1:0]          cfg_wdata,
    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entry_index[11:0], entry_data[43:12], query_x[75:44], query_y[107:76]
    input  logic [bgi_pkg::S_TDATA_W-1:0]       s_tdata,
    // func[1:0]
    input  logic [1:0]                          s_tuser,
    input  logic                                s_tlast,
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // interp_value[31:0]
    output logic [bgi_pkg::M_TDATA_W-1:0]       m_tdata,
    // interp_status[1:0]
    output logic [1:0]                          m_tuser,
    output logic                                m_tlast
);
    import bgi_pkg::*;

    localparam int SA_W  = 2 * NPTS_W;
    localparam int NUM_W = 98;   // signed sum of four 96-bit terms
    localparam int T_W   = 96;

    localparam logic [3:0] T_IDLE   = 4'd0;
    localparam logic [3:0] T_SEARCH = 4'd1;
    localparam logic [3:0] T_DIFF   = 4'd2;
    localparam logic [3:0] T_ADDR   = 4'd3;
    localparam logic [3:0] T_VAL    = 4'd4;
    localparam logic [3:0] T_MLO    = 4'd5;
    localparam logic [3:0] T_MHI    = 4'd6;
    localparam logic [3:0] T_ACC    = 4'd7;
    localparam logic [3:0] T_NORM   = 4'd8;
    localparam logic [3:0] T_OVF    = 4'd9;
    localparam logic [3:0] T_DIV    = 4'd10;
    localparam logic [3:0] T_SAT    = 4'd11;
    localparam logic [3:0] T_OUT    = 4'd12;

    function automatic logic [DATA_W-1:0] mag33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W:0] n;
        n = -v;
        return v[DATA_W] ? n[DATA_W-1:0] : v[DATA_W-1:0];
    endfunction

    function automatic logic [NPTS_W-1:0] clamp_points(input logic [NPTS_W-1:0] v);
        if (v < NPTS_W'(2))               return NPTS_W'(2);
        else if (v > NPTS_W'(AXIS_DEPTH)) return NPTS_W'(AXIS_DEPTH);
        else                              return v;
    endfunction

    // ---- request fields
    logic [IDX_W-1:0]         f_idx;
    logic [DATA_W-1:0]        f_data;
    logic signed [DATA_W-1:0] f_qx, f_qy;
    assign f_idx  = s_tdata[11:0];
    assign f_data = s_tdata[43:12];
    assign f_qx   = $signed(s_tdata[75:44]);
    assign f_qy   = $signed(s_tdata[107:76]);

    logic [3:0]               state_reg;
    logic [NPTS_W-1:0]        nx_reg, ny_reg;
    logic                     s_acc, q_start;
    logic signed [DATA_W-1:0] qx_reg, qy_reg;
    logic                     last_reg;

    assign s_tready = (state_reg == T_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign q_start  = s_acc && (s_tuser == FUNC_QUERY);

    // ---- configuration: counts are clamped on write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nx_reg <= NPTS_W'(AXIS_DEPTH);
            ny_reg <= NPTS_W'(AXIS_DEPTH);
        end else if (cfg_we) begin
            if (cfg_index == CFG_REG_X) nx_reg <= clamp_points(cfg_wdata);
            if (cfg_index == CFG_REG_Y) ny_reg <= clamp_points(cfg_wdata);
        end
    end

    // ---- axis units
    axis_wr_t  wr_x, wr_y;
    axis_res_t ax1, ax2;
    logic      idx_in_axis;

    assign idx_in_axis = (f_idx < IDX_W'(AXIS_DEPTH));
    assign wr_x.en   = s_acc && (s_tuser == FUNC_WR_X) && idx_in_axis;
    assign wr_x.addr = f_idx[AXIS_AW-1:0];
    assign wr_x.data = f_data;
    assign wr_y.en   = s_acc && (s_tuser == FUNC_WR_Y) && idx_in_axis;
    assign wr_y.addr = f_idx[AXIS_AW-1:0];
    assign wr_y.data = f_data;

    bgi_axis u_axis_x (
        .aclk(aclk), .aresetn(aresetn), .wr(wr_x), .start(q_start),
        .coord(f_qx), .npts(nx_reg), .res(ax1)
    );
    bgi_axis u_axis_y (
        .aclk(aclk), .aresetn(aresetn), .wr(wr_y), .start(q_start),
        .coord(f_qy), .npts(ny_reg), .res(ax2)
    );

    // ---- sample store, row-major
    logic                 smp_we;
    logic [SA_W-1:0]      sa_full;
    logic [DATA_W-1:0]    smp_rdata;
    logic [1:0]           k_reg;
    logic [NPTS_W-1:0]    row_i, col_j;

    assign smp_we  = s_acc && (s_tuser == FUNC_WR_S) &&
                     ((IDX_W+1)'(f_idx) < (IDX_W+1)'(SAMPLE_DEPTH));
    assign row_i   = NPTS_W'(ax1.j) + NPTS_W'(k_reg[1]);
    assign col_j   = NPTS_W'(ax2.j) + NPTS_W'(k_reg[0]);
    assign sa_full = SA_W'(row_i) * SA_W'(ny_reg) + SA_W'(col_j);

    bgi_ram #(.WIDTH(DATA_W), .DEPTH(SAMPLE_DEPTH)) u_samples (
        .clk   (aclk),
        .we    (smp_we),
        .waddr (f_idx[SAMPLE_AW-1:0]),
        .wdata (f_data),
        .raddr (sa_full[SAMPLE_AW-1:0]),
        .rdata (smp_rdata)
    );

    // ---- datapath
    logic signed [DATA_W:0] d10_reg, d11_reg, d20_reg, d21_reg, w1_reg, w2_reg;
    logic signed [DATA_W:0] w1_c, w2_c, da, db;
    logic [2*DATA_W-1:0]    p_reg, plo_reg, phi_reg, den_reg;
    logic                   pneg_reg, tn_reg, oor_reg, neg_reg;
    logic [DATA_W-1:0]      vmag_reg;
    logic [NUM_W-1:0]       num_reg, num_neg;
    logic [T_W-1:0]         t_c;
    logic [NUM_W-2:0]       nmag_reg;
    logic [2*DATA_W-1:0]    rem_reg;
    logic [2*DATA_W:0]      r2, r2_sub;
    logic                   r2_ge;
    logic [DATA_W-1:0]      dvd_reg, q_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DATA_W-1:0]      res_val_reg, out_data_reg;
    logic [1:0]             res_stat_reg, out_stat_reg;
    logic                   out_valid_reg, out_last_reg;
    logic signed [DATA_W-1:0] v_s;

    assign w1_c = $signed({ax1.g_hi[DATA_W-1], ax1.g_hi}) -
                  $signed({ax1.g_lo[DATA_W-1], ax1.g_lo});
    assign w2_c = $signed({ax2.g_hi[DATA_W-1], ax2.g_hi}) -
                  $signed({ax2.g_lo[DATA_W-1], ax2.g_lo});
    assign da   = k_reg[1] ? d11_reg : d10_reg;
    assign db   = k_reg[0] ? d21_reg : d20_reg;
    assign v_s  = $signed(smp_rdata);
    assign t_c  = T_W'(plo_reg) + {phi_reg, 32'b0};
    assign num_neg = -NUM_W'(t_c);
    assign r2     = {rem_reg, dvd_reg[DATA_W-1]};
    assign r2_ge  = (r2 >= {1'b0, den_reg});
    assign r2_sub = r2 - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            // load a new result, or drop the one just taken
            if (state_reg == T_OUT && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE:   if (q_start) state_reg <= T_SEARCH;
                T_SEARCH: if (!ax1.busy && !ax2.busy) state_reg <= T_DIFF;
                T_DIFF:   state_reg <= (w1_c == '0 || w2_c == '0) ? T_OUT : T_ADDR;
                T_ADDR:   state_reg <= T_VAL;
                T_VAL:    state_reg <= T_MLO;
                T_MLO:    state_reg <= T_MHI;
                T_MHI:    state_reg <= T_ACC;
                T_ACC:    state_reg <= (k_reg == 2'd3) ? T_NORM : T_ADDR;
                T_NORM:   state_reg <= T_OVF;
                T_OVF:    state_reg <= (NUM_W'(nmag_reg) >= NUM_W'({den_reg, 32'b0}))
                                       ? T_OUT : T_DIV;
                T_DIV:    if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) state_reg <= T_SAT;
                T_SAT:    state_reg <= T_OUT;
                T_OUT:    if (!out_valid_reg || m_tready) state_reg <= T_IDLE;
                default:  state_reg <= T_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            T_IDLE: begin
                if (q_start) begin
                    qx_reg   <= f_qx;
                    qy_reg   <= f_qy;
                    last_reg <= s_tlast;
                end
            end
            T_SEARCH: ;
            T_DIFF: begin
                d10_reg <= $signed({ax1.g_hi[DATA_W-1], ax1.g_hi}) -
                           $signed({qx_reg[DATA_W-1], qx_reg});
                d11_reg <= $signed({qx_reg[DATA_W-1], qx_reg}) -
                           $signed({ax1.g_lo[DATA_W-1], ax1.g_lo});
                d20_reg <= $signed({ax2.g_hi[DATA_W-1], ax2.g_hi}) -
                           $signed({qy_reg[DATA_W-1], qy_reg});
                d21_reg <= $signed({qy_reg[DATA_W-1], qy_reg}) -
                           $signed({ax2.g_lo[DATA_W-1], ax2.g_lo});
                w1_reg  <= w1_c;
                w2_reg  <= w2_c;
                k_reg   <= '0;
                num_reg <= '0;
                res_val_reg  <= '0;
                res_stat_reg <= STAT_ZERO_W;
            end
            T_ADDR: begin
                p_reg    <= mag33(da) * mag33(db);
                pneg_reg <= da[DATA_W] ^ db[DATA_W];
                oor_reg  <= (sa_full >= SA_W'(SAMPLE_DEPTH));
            end
            T_VAL: begin
                // corner off the end of the table counts as zero
                vmag_reg <= oor_reg ? '0 : mag33({v_s[DATA_W-1], v_s});
                tn_reg   <= pneg_reg ^ (v_s[DATA_W-1] && !oor_reg);
            end
            T_MLO: plo_reg <= p_reg[DATA_W-1:0] * vmag_reg;
            T_MHI: phi_reg <= p_reg[2*DATA_W-1:DATA_W] * vmag_reg;
            T_ACC: begin
                num_reg <= num_reg + (tn_reg ? num_neg : NUM_W'(t_c));
                k_reg   <= k_reg + 2'd1;
            end
            T_NORM: begin
                nmag_reg <= num_reg[NUM_W-1] ? (NUM_W-1)'(-num_reg)
                                             : num_reg[NUM_W-2:0];
                neg_reg  <= num_reg[NUM_W-1] ^ w1_reg[DATA_W] ^ w2_reg[DATA_W];
                den_reg  <= mag33(w1_reg) * mag33(w2_reg);
            end
            T_OVF: begin
                // quotient >= 2^32 saturates either way
                rem_reg      <= nmag_reg[2*DATA_W+DATA_W-1:DATA_W];
                dvd_reg      <= nmag_reg[DATA_W-1:0];
                q_reg        <= '0;
                cnt_reg      <= '0;
                res_val_reg  <= neg_reg ? SAT_NEG : SAT_POS;
                res_stat_reg <= STAT_SAT;
            end
            T_DIV: begin
                rem_reg <= r2_ge ? r2_sub[2*DATA_W-1:0] : r2[2*DATA_W-1:0];
                q_reg   <= {q_reg[DATA_W-2:0], r2_ge};
                dvd_reg <= dvd_reg << 1;
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
            end
            T_SAT: begin
                if (neg_reg) begin
                    if (q_reg > SAT_NEG) begin
                        res_val_reg  <= SAT_NEG;
                        res_stat_reg <= STAT_SAT;
                    end else begin
                        res_val_reg  <= -q_reg;
                        res_stat_reg <= STAT_OK;
                    end
                end else begin
                    if (q_reg > SAT_POS) begin
                        res_val_reg  <= SAT_POS;
                        res_stat_reg <= STAT_SAT;
                    end else begin
                        res_val_reg  <= q_reg;
                        res_stat_reg <= STAT_OK;
                    end
                end
            end
            T_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_data_reg <= res_val_reg;
                    out_stat_reg <= res_stat_reg;
                    out_last_reg <= last_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tlast  = out_last_reg;

    // ---- checks
    a_axes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == T_IDLE |-> !ax1.busy && !ax2.busy)
        else $error("axis search running while core idle");

    a_stat_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_stat_reg == STAT_OK || out_stat_reg == STAT_SAT ||
                          out_stat_reg == STAT_ZERO_W)
        else $error("bad result status");

    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_stat_reg == STAT_SAT |->
            out_data_reg == SAT_POS || out_data_reg == SAT_NEG)
        else $error("saturated result not at a limit");

    a_zero_val: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_stat_reg == STAT_ZERO_W |-> out_data_reg == '0)
        else $error("zero-width result not zero");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(q_start) |-> state_reg == T_SEARCH && ax1.busy && ax2.busy)
        else $error("query did not start both searches");

endmodule
